// ===== rtl/core/mh2_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// char-pair MurmurHash2-style string hash. No dependencies.
`default_nettype none

package mh2_pkg;

   localparam logic [31:0] HASH_M     = 32'h5bd1e995;
   localparam int unsigned HASH_R     = 24;
   localparam int unsigned FIN_S1     = 13;
   localparam int unsigned FIN_S2     = 15;
   localparam int unsigned HIGH_SHIFT = 16;
   localparam int unsigned CHAR_W     = 16;
   localparam int unsigned LEN_W      = 31;
   localparam int unsigned HASH_W     = 32;

   // Operand selection for the single shared multiplier.
   typedef enum logic [1:0] {
      MUL_PART     = 2'd0,
      MUL_PART_MIX = 2'd1,
      MUL_HASH     = 2'd2,
      MUL_HASH_FIN = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        part_wr;
      logic        hash_wr;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic in_has_chars;
      logic in_last;
      logic held_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/murmur2_char_pair_string_hash.sv =====
// Top level of the char-pair MurmurHash2-style string hash.
// Instantiates mh2_ctrl and mh2_datapath; uses mh2_pkg.
//
// Each accepted item is loaded from the input in the idle state; an item that
// carries characters then takes two mixing multiplies and the running-hash
// multiply, and a last item adds the finalising multiply and the result write.
// All multiplies share one 32-bit constant multiplier, and no new item is taken
// until the last one is through. A finished hash waits in an output register
// while the next item is taken; a last item only stalls in its emit step if that
// result is still unread. csr_ready is always high; write csr_wide_chars only while idle.
`default_nettype none

module murmur2_char_pair_string_hash (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_first_item,
   input  wire logic [30:0]  req_total_length,
   input  wire logic [15:0]  req_char_low,
   input  wire logic [15:0]  req_char_high,
   input  wire logic [1:0]   req_char_count,
   input  wire logic         req_last_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [31:0]       rsp_hash_value,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_wide_chars
);
   import mh2_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mh2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mh2_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_first_item   (req_first_item),
      .req_total_length (req_total_length),
      .req_char_low     (req_char_low),
      .req_char_high    (req_char_high),
      .req_char_count   (req_char_count),
      .req_last_item    (req_last_item),
      .csr_valid        (csr_valid && csr_ready),
      .csr_wide_chars   (csr_wide_chars),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mh2_datapath.sv =====
// Datapath of the string hash: part and hash registers, one shared constant
// multiplier, the character width register and the result register. Uses mh2_pkg.
`default_nettype none

module mh2_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mh2_pkg::cmd_type    cmd,
   output mh2_pkg::status_type      status,
   input  wire logic                req_first_item,
   input  wire logic [30:0]         req_total_length,
   input  wire logic [15:0]         req_char_low,
   input  wire logic [15:0]         req_char_high,
   input  wire logic [1:0]          req_char_count,
   input  wire logic                req_last_item,
   input  wire logic                csr_valid,
   input  wire logic                csr_wide_chars,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [31:0]              rsp_hash_value
);
   import mh2_pkg::*;

   logic              wide_ff, wide_in;
   logic [HASH_W-1:0] part_ff, part_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;

   logic [CHAR_W-1:0] char_mask;
   logic [CHAR_W-1:0] c0;
   logic [CHAR_W-1:0] c1;
   logic [HASH_W-1:0] mul_op;
   logic [HASH_W-1:0] product;
   logic              out_free;

   assign char_mask = wide_ff ? {CHAR_W{1'b1}} : CHAR_W'(16'h00ff);
   assign c0        = req_char_low & char_mask;
   assign c1        = req_char_high & char_mask;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.mul_sel)
         MUL_PART:     mul_op = part_ff;
         MUL_PART_MIX: mul_op = part_ff ^ (part_ff >> HASH_R);
         MUL_HASH:     mul_op = hash_ff;
         MUL_HASH_FIN: mul_op = hash_ff ^ (hash_ff >> FIN_S1);
         default:      mul_op = part_ff;
      endcase
   end

   assign product = mul_op * HASH_M;

   always_comb begin
      wide_in      = csr_valid ? csr_wide_chars : wide_ff;
      part_in      = part_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         // A count of three carries a pair, the same as two.
         if (req_char_count == 2'd1) begin
            part_in = {{(HASH_W-CHAR_W){1'b0}}, c0};
         end else begin
            part_in = {c1, c0};
         end
         if (req_first_item) begin
            hash_in = {1'b0, req_total_length};
         end
         last_in = req_last_item;
      end
      if (cmd.part_wr) begin
         part_in = product;
      end
      if (cmd.hash_wr) begin
         hash_in = product ^ part_ff;
      end
      if (cmd.emit) begin
         // The finalising product waits in the part register.
         rsp_hash_in  = part_ff ^ (part_ff >> FIN_S2);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff      <= 1'b0;
         hash_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wide_ff      <= wide_in;
         hash_ff      <= hash_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      part_ff     <= part_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign status.in_has_chars = req_char_count != 2'd0;
   assign status.in_last      = req_last_item;
   assign status.held_last    = last_ff;
   assign status.out_free     = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mh2_ctrl.sv =====
// Sequencer of the string hash: steps one item through the shared
// multiplier and drives the input stall. Uses mh2_pkg.
`default_nettype none

module mh2_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire mh2_pkg::status_type  status,
   output mh2_pkg::cmd_type          cmd
);
   import mh2_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MIX1 = 6'b000010,
      ST_MIX2 = 6'b000100,
      ST_MIX3 = 6'b001000,
      ST_FIN1 = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.mul_sel = MUL_PART;
      cmd.part_wr = 1'b0;
      cmd.hash_wr = 1'b0;
      cmd.emit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (status.in_has_chars) begin
                  state_in = ST_MIX1;
               end else if (status.in_last) begin
                  state_in = ST_FIN1;
               end
            end
         end
         ST_MIX1: begin
            cmd.mul_sel = MUL_PART;
            cmd.part_wr = 1'b1;
            state_in    = ST_MIX2;
         end
         ST_MIX2: begin
            cmd.mul_sel = MUL_PART_MIX;
            cmd.part_wr = 1'b1;
            state_in    = ST_MIX3;
         end
         ST_MIX3: begin
            cmd.mul_sel = MUL_HASH;
            cmd.hash_wr = 1'b1;
            state_in    = status.held_last ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.mul_sel = MUL_HASH_FIN;
            cmd.part_wr = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold here until the previous result has been taken.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_empty_item_idles: assert property (@(posedge clock) disable iff (reset)
      accept && !status.in_has_chars && !status.in_last |=> state_ff == ST_IDLE)
      else $error("item without characters or result did not return to idle");

   a_fin_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN1 |=> state_ff == ST_EMIT)
      else $error("finalisation not followed by emit");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result written over an item not yet taken");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.part_wr && cmd.hash_wr) && !(cmd.load && (cmd.part_wr || cmd.emit)))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== tb/murmur2_char_pair_string_hash_tb.sv =====
// Self-checking testbench for murmur2_char_pair_string_hash: directed and random strings,
// with a queue-fed driver, a checking monitor and an in-bench hash predictor.
// Depends on mh2_pkg for the hash constants and on the RTL top level only.
`timescale 1ns / 100ps

module murmur2_char_pair_string_hash_tb;
   import mh2_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 12;

   typedef struct packed {
      logic              first;
      logic [LEN_W-1:0]  total;
      logic [CHAR_W-1:0] lo;
      logic [CHAR_W-1:0] hi;
      logic [1:0]        count;
      logic              last;
   } hash_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   hash_req_type offer = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [31:0]  rsp_hash_value;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_wide_chars = 1'b0;

   hash_req_type pending_items[$];
   logic [31:0]  expected_hashes[$];
   logic [31:0]  acc_hash = '0;
   logic         model_wide = 1'b0;
   int unsigned  items_queued = 0;
   int unsigned  mismatches = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  hold_left = 0;
   int unsigned  quiet_cycles = 0;

   murmur2_char_pair_string_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_item   (offer.first),
      .req_total_length (offer.total),
      .req_char_low     (offer.lo),
      .req_char_high    (offer.hi),
      .req_char_count   (offer.count),
      .req_last_item    (offer.last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wide_chars   (csr_wide_chars)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] mix_word(input logic [31:0] w);
      logic [31:0] m;
      m = w * HASH_M;
      m = m ^ (m >> HASH_R);
      m = m * HASH_M;
      return m;
   endfunction

   // Folds one accepted item into the running hash; a last item queues its finalised hash.
   task automatic absorb_item(input hash_req_type it);
      logic [15:0] mask;
      logic [31:0] part;
      logic [31:0] h;
      mask = model_wide ? 16'hffff : 16'h00ff;
      if (it.first)
         acc_hash = {1'b0, it.total};
      if (it.count != 2'd0) begin
         part = {16'h0000, it.lo & mask};
         if (it.count >= 2'd2)
            part[31:16] = it.hi & mask;
         acc_hash = (acc_hash * HASH_M) ^ mix_word(part);
      end
      if (it.last) begin
         h = acc_hash;
         h = h ^ (h >> FIN_S1);
         h = h * HASH_M;
         h = h ^ (h >> FIN_S2);
         expected_hashes.push_back(h);
      end
   endtask

   task automatic push_item(input logic first, input logic [30:0] total, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [1:0] count, input logic last);
      hash_req_type it;
      it.first = first;
      it.total = total;
      it.lo = lo;
      it.hi = hi;
      it.count = count;
      it.last = last;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Mostly well-formed strings with random content; the rest are stray items of any shape.
   task automatic push_random_string();
      int unsigned n_chars;
      int unsigned left;
      logic [30:0] seed;
      logic [1:0]  cnt;
      logic        is_first;
      if ($urandom_range(0, 99) < 85) begin
         n_chars = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 64) : $urandom_range(0, 9);
         seed = 31'(n_chars);
         if ($urandom_range(0, 9) == 0)
            seed = 31'($urandom());
         if (n_chars == 0) begin
            push_item(1'b1, seed, 16'($urandom()), 16'($urandom()), 2'd0, 1'b1);
         end else begin
            left = n_chars;
            is_first = 1'b1;
            while (left > 0) begin
               cnt = (left >= 2) ? 2'd2 : 2'd1;
               left = left - cnt;
               // A count of three carries two characters as well.
               if (cnt == 2'd2 && $urandom_range(0, 19) == 0)
                  cnt = 2'd3;
               push_item(is_first, is_first ? seed : 31'($urandom()), 16'($urandom()),
                         16'($urandom()), cnt, left == 0);
               is_first = 1'b0;
            end
         end
      end else begin
         push_item(1'($urandom_range(0, 1)), 31'($urandom()), 16'($urandom()),
                   16'($urandom()), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic push_random_items(input int unsigned n);
      int unsigned start;
      start = items_queued;
      while (items_queued - start < n)
         push_random_string();
   endtask

   // Returns at a falling edge once all items are in, all hashes are out and the core is quiet.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_hashes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_wide(input logic wide);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wide_chars <= wide;
      do
         @(posedge clock);
      while (!csr_ready);
      model_wide = wide;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            absorb_item(offer);
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offer <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $error("hash_value: unexpected result, expected none, actual %08h",
                      rsp_hash_value);
               mismatches++;
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %08h, actual %08h", want, rsp_hash_value);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 34;
      recv_idle_pct = 53;

      write_wide(1'b0);
      // Byte characters: an item with no first after reset, then the empty string.
      push_item(1'b0, 31'd0, 16'h1234, 16'hffff, 2'd1, 1'b1);
      push_item(1'b1, 31'd0, 16'h0000, 16'h0000, 2'd0, 1'b1);
      push_item(1'b1, 31'h7fffffff, 16'hffff, 16'hffff, 2'd2, 1'b1);
      push_item(1'b1, 31'd3, 16'h0041, 16'h0042, 2'd2, 1'b0);
      push_item(1'b0, 31'd0, 16'h0043, 16'hffff, 2'd1, 1'b1);
      // Mixing carries on past a last item when no new first arrives.
      push_item(1'b0, 31'd0, 16'hff00, 16'h00ff, 2'd2, 1'b1);
      push_item(1'b1, 31'd2, 16'h0061, 16'h0062, 2'd3, 1'b1);
      push_item(1'b1, 31'd4, 16'h0031, 16'h0032, 2'd2, 1'b0);
      push_item(1'b0, 31'd0, 16'h0055, 16'h0066, 2'd0, 1'b0);
      push_item(1'b0, 31'd0, 16'h0033, 16'h0034, 2'd2, 1'b1);
      // The seed disagrees with the characters that actually arrive.
      push_item(1'b1, 31'd1, 16'h0010, 16'h0020, 2'd2, 1'b0);
      push_item(1'b0, 31'd0, 16'h0030, 16'h0000, 2'd2, 1'b1);
      push_item(1'b1, 31'd0, 16'h0000, 16'h0000, 2'd2, 1'b1);
      wait_drained();

      write_wide(1'b1);
      push_item(1'b1, 31'h7fffffff, 16'hffff, 16'hffff, 2'd2, 1'b1);
      push_item(1'b1, 31'd1, 16'h8000, 16'h0001, 2'd1, 1'b1);
      push_item(1'b1, 31'd2, 16'habcd, 16'h1234, 2'd3, 1'b1);
      push_item(1'b1, 31'd0, 16'h0000, 16'h0000, 2'd0, 1'b1);
      push_item(1'b0, 31'd0, 16'h0001, 16'h8000, 2'd2, 1'b0);
      push_item(1'b0, 31'd0, 16'hffff, 16'h0000, 2'd1, 1'b1);
      wait_drained();

      // Hold the result side off so the core backs up while items keep coming.
      hold_left = 300;
      push_random_items(150);
      wait_drained();
      push_random_items(220);
      wait_drained();

      write_wide(1'b0);
      send_idle_pct = 53;
      recv_idle_pct = 34;
      push_random_items(370);
      wait_drained();

      write_wide(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random_items(180);
      wait_drained();
      write_wide(1'b0);
      push_random_items(180);
      wait_drained();

      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mh2_pkg.sv
rtl/core/mh2_datapath.sv
rtl/core/mh2_ctrl.sv
rtl/core/murmur2_char_pair_string_hash.sv
tb/murmur2_char_pair_string_hash_tb.sv
